// File: design/ctds_pkg.sv
// Package for the cold tank drain sequencer: codes, valve masks and shared types.
package ctds_pkg;

    // Event codes carried in the action field
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    // Sequence phases
    localparam logic [2:0] PH_READY  = 3'd0;
    localparam logic [2:0] PH_SETTLE = 3'd1;
    localparam logic [2:0] PH_DRAIN  = 3'd2;
    localparam logic [2:0] PH_CLOSE  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_FAUCET_LIMIT = 2'd0;
    localparam logic [1:0] CFG_DRAIN_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_SETTLE_TICKS = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] FAUCET_LIMIT_RST = 16'd3400;
    localparam logic [15:0] DRAIN_LIMIT_RST  = 16'd7200;
    localparam logic [7:0]  SETTLE_TICKS_RST = 8'd2;

    // Valve command bits
    localparam logic [3:0] VLV_INLET  = 4'b0001;
    localparam logic [3:0] VLV_FAUCET = 4'b0010;
    localparam logic [3:0] VLV_DRAIN  = 4'b0100;
    localparam logic [3:0] VLV_VENT   = 4'b1000;

    typedef struct packed {
        logic [15:0] faucet_limit;
        logic [15:0] drain_limit;
        logic [7:0]  settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] action;
        logic       drain_kind;
        logic       fault;
    } item_t;

    typedef struct packed {
        logic        active;
        logic        kind;
        logic [2:0]  phase;
        logic [7:0]  settle_count;
        logic [15:0] exit_count;
        logic [3:0]  valve_cmds;
    } seq_state_t;

endpackage

// File: design/ctds_if.sv
// Channel interfaces for the cold tank drain sequencer.
interface ctds_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       drain_kind;
    logic       fault;

    modport source (output valid, output action, output drain_kind, output fault, input ready);
    modport sink   (input valid, input action, input drain_kind, input fault, output ready);
endinterface

interface ctds_result_if;
    logic        valid;
    logic        ready;
    logic        running;
    logic        finished;
    logic [2:0]  phase;
    logic [15:0] remaining_ticks;
    logic        inlet_open;
    logic        faucet_outlet_open;
    logic        drain_open;
    logic        vent_open;

    modport source (output valid, output running, output finished, output phase,
                    output remaining_ticks, output inlet_open, output faucet_outlet_open,
                    output drain_open, output vent_open, input ready);
    modport sink   (input valid, input running, input finished, input phase,
                    input remaining_ticks, input inlet_open, input faucet_outlet_open,
                    input drain_open, input vent_open, output ready);
endinterface

// File: design/cold_tank_drain_sequencer.sv
// Top level of the cold tank drain sequencer: state, configuration and result register.
//
// Valve sequencer that empties the cold tank through the faucet outlet or the
// drain valve. Every input transaction is one event (tick, start or stop) and
// yields exactly one result transaction that reports the state after the event.
// An event needs no multi-step work: the sequence state sits in registers, the
// next state is short logic, and the result lands in an output register in the
// cycle after acceptance. Sustained rate is one transaction per clock; input
// ready only drops while the output register holds a result that the sink has
// not taken. Configuration is written through cfg_we/cfg_index/cfg_data and
// must only change while no transaction is in flight; writes to an index
// outside the register list are dropped.
module cold_tank_drain_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    ctds_item_if.sink            item,
    ctds_result_if.source        result
);
    import ctds_pkg::*;

    cfg_t       cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    item_t      item_in;
    logic       finished_next;
    logic       accept;

    // Output register
    logic        out_valid_reg;
    logic        finished_reg;
    seq_state_t report_reg;

    assign item_in.action     = item.action;
    assign item_in.drain_kind = item.drain_kind;
    assign item_in.fault      = item.fault;

    // A new event may enter whenever the output slot is empty or being drained
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    ctds_next u_next (
        .cur      (state_reg),
        .item     (item_in),
        .cfg      (cfg_reg),
        .nxt      (state_next),
        .finished (finished_next)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.faucet_limit <= FAUCET_LIMIT_RST;
            cfg_reg.drain_limit  <= DRAIN_LIMIT_RST;
            cfg_reg.settle_ticks <= SETTLE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            priority case (cfg_index)
                CFG_FAUCET_LIMIT: cfg_reg.faucet_limit <= cfg_data;
                CFG_DRAIN_LIMIT:  cfg_reg.drain_limit  <= cfg_data;
                CFG_SETTLE_TICKS: cfg_reg.settle_ticks <= cfg_data[7:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Sequence state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload: loaded with each accepted transaction, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            report_reg   <= state_next;
            finished_reg <= finished_next;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.running            = report_reg.active;
    assign result.finished           = finished_reg;
    assign result.phase              = report_reg.phase;
    assign result.remaining_ticks    = report_reg.exit_count;
    assign result.inlet_open         = |(report_reg.valve_cmds & VLV_INLET);
    assign result.faucet_outlet_open = |(report_reg.valve_cmds & VLV_FAUCET);
    assign result.drain_open         = |(report_reg.valve_cmds & VLV_DRAIN);
    assign result.vent_open          = |(report_reg.valve_cmds & VLV_VENT);

    // Every accepted transaction shows up in the output slot on the next cycle
    a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted transaction did not reach the output register");

    // Completion always drops running on the same result
    a_finished_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.finished) |-> !result.running)
        else $error("finished reported while still running");

    // Phase stays within the defined codes
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.phase <= PH_DONE))
        else $error("phase code beyond done");

    // Draining never opens the inlet
    a_inlet_closed: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !result.inlet_open)
        else $error("inlet commanded open");

endmodule

// File: design/ctds_next.sv
// Next-state logic of the drain sequence for one event.
module ctds_next (
    input  ctds_pkg::seq_state_t cur,
    input  ctds_pkg::item_t      item,
    input  ctds_pkg::cfg_t       cfg,
    output ctds_pkg::seq_state_t nxt,
    output logic                 finished
);
    import ctds_pkg::*;

    logic [2:0] ph;
    logic [3:0] outlet;
    logic       closable;

    assign outlet   = cur.kind ? VLV_DRAIN : VLV_FAUCET;
    assign closable = cur.active && (cur.phase <= PH_DRAIN);

    always_comb
    begin
        nxt      = cur;
        finished = 1'b0;
        // fault forces closing before the step is taken
        ph       = (item.fault && closable) ? PH_CLOSE : cur.phase;
        unique case (item.action)
            ACT_TICK:
            begin
                if (cur.active)
                begin
                    nxt.phase = ph;
                    unique case (ph)
                        PH_READY:
                        begin
                            nxt.valve_cmds   = VLV_VENT;
                            nxt.exit_count   = cur.kind ? cfg.drain_limit
                                                        : cfg.faucet_limit;
                            nxt.settle_count = cfg.settle_ticks;
                            nxt.phase        = PH_SETTLE;
                        end
                        PH_SETTLE:
                        begin
                            if (cur.settle_count != 8'd0)
                            begin
                                nxt.settle_count = cur.settle_count - 8'd1;
                            end
                            else
                            begin
                                nxt.valve_cmds = cur.valve_cmds | outlet;
                                nxt.phase      = PH_DRAIN;
                            end
                        end
                        PH_DRAIN:
                        begin
                            nxt.valve_cmds = (cur.valve_cmds & ~(VLV_INLET | VLV_DRAIN))
                                             | VLV_VENT | outlet;
                            if (cur.exit_count != 16'd0)
                            begin
                                nxt.exit_count = cur.exit_count - 16'd1;
                            end
                            else
                            begin
                                nxt.phase = PH_CLOSE;
                            end
                        end
                        PH_CLOSE:
                        begin
                            nxt.valve_cmds = VLV_VENT;
                            nxt.phase      = PH_DONE;
                        end
                        PH_DONE:
                        begin
                            nxt.active = 1'b0;
                            finished   = 1'b1;
                        end
                        default:
                        begin
                            nxt.phase = PH_READY;
                        end
                    endcase
                end
            end
            ACT_START:
            begin
                nxt.active = 1'b1;
                nxt.kind   = item.drain_kind;
                nxt.phase  = PH_READY;
            end
            ACT_STOP:
            begin
                if (closable)
                begin
                    nxt.phase = PH_CLOSE;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// File: test/cold_tank_drain_sequencer_test.sv
// Self-checking testbench for the cold tank drain sequencer.
module cold_tank_drain_sequencer_test;
    import ctds_pkg::*;

    // Action code 3 has no meaning; the block must ignore it
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Cycles with no transaction on either channel before the run is abandoned.
    // Longest legitimate quiet spell is the deliberate sink hold-off below.
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned SINK_HOLDOFF = 300;
    // Result register is loaded in the cycle after acceptance; wait_idle adds this guard
    localparam int unsigned DRAIN_GUARD  = 4;
    localparam int unsigned ITEMS_PER_SETTING = 200;
    localparam int unsigned SETTING_COUNT     = 8;

    // One result transaction as the sink sees it
    typedef struct packed {
        logic        running;
        logic        finished;
        logic [2:0]  phase;
        logic [15:0] remaining;
        logic        inlet;
        logic        faucet;
        logic        drain;
        logic        vent;
    } drain_report_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    ctds_item_if   item_ch ();
    ctds_result_if result_ch ();

    cold_tank_drain_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    // Shadow copy of the configuration registers, reset values from the package
    logic [15:0] cfg_faucet_to = FAUCET_LIMIT_RST;
    logic [15:0] cfg_drain_to  = DRAIN_LIMIT_RST;
    logic [7:0]  cfg_settle    = SETTLE_TICKS_RST;

    // Shadow copy of the sequencer state
    logic        tank_active = 1'b0;
    logic        tank_kind   = 1'b0;
    logic [2:0]  tank_phase  = PH_READY;
    logic [7:0]  settle_left = 8'd0;
    logic [15:0] ticks_left  = 16'd0;
    logic [3:0]  valve_state = 4'b0000;

    drain_report_t pending_reports[$];
    int unsigned   mismatches = 0;

    // Idle behaviour of each side, in percent of cycles
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    // Cycles for which the sink refuses everything; counted down by the sink process
    int unsigned sink_hold      = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sequencer prediction: apply one event to the shadow state and return
    // the result the block should report for it.
    // ------------------------------------------------------------------
    function automatic drain_report_t advance_sequence(input logic [1:0] act,
                                                       input logic knd,
                                                       input logic flt);
        drain_report_t rpt;
        logic [3:0]    outlet;
        logic          done_now;

        done_now = 1'b0;
        case (act)
            ACT_TICK:
            begin
                // Idle ticks change nothing, fault flag included
                if (tank_active)
                begin
                    // A fault forces closing before this tick's step is taken
                    if (flt && tank_phase <= PH_DRAIN)
                        tank_phase = PH_CLOSE;
                    outlet = tank_kind ? VLV_DRAIN : VLV_FAUCET;
                    case (tank_phase)
                        PH_READY:
                        begin
                            valve_state = VLV_VENT;
                            ticks_left  = tank_kind ? cfg_drain_to : cfg_faucet_to;
                            settle_left = cfg_settle;
                            tank_phase  = PH_SETTLE;
                        end
                        PH_SETTLE:
                        begin
                            if (settle_left != 8'd0)
                                settle_left = settle_left - 8'd1;
                            else
                            begin
                                valve_state = valve_state | outlet;
                                tank_phase  = PH_DRAIN;
                            end
                        end
                        PH_DRAIN:
                        begin
                            valve_state = (valve_state & ~(VLV_INLET | VLV_DRAIN))
                                          | VLV_VENT | outlet;
                            if (ticks_left != 16'd0)
                                ticks_left = ticks_left - 16'd1;
                            else
                                tank_phase = PH_CLOSE;
                        end
                        PH_CLOSE:
                        begin
                            valve_state = VLV_VENT;
                            tank_phase  = PH_DONE;
                        end
                        PH_DONE:
                        begin
                            tank_active = 1'b0;
                            done_now    = 1'b1;
                        end
                        default:
                            tank_phase = PH_READY;
                    endcase
                end
            end
            ACT_START:
            begin
                // Restart from ready; valves wait for the next tick
                tank_active = 1'b1;
                tank_kind   = knd;
                tank_phase  = PH_READY;
            end
            ACT_STOP:
            begin
                if (tank_active && tank_phase <= PH_DRAIN)
                    tank_phase = PH_CLOSE;
            end
            default:
                ;
        endcase

        rpt.running   = tank_active;
        rpt.finished  = done_now;
        rpt.phase     = tank_phase;
        rpt.remaining = ticks_left;
        rpt.inlet     = |(valve_state & VLV_INLET);
        rpt.faucet    = |(valve_state & VLV_FAUCET);
        rpt.drain     = |(valve_state & VLV_DRAIN);
        rpt.vent      = |(valve_state & VLV_VENT);
        return rpt;
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
            note_failure($sformatf("%s expected %0d, got %0d", name, want, got));
    endfunction

    // ------------------------------------------------------------------
    // Result checker: each accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        drain_report_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_reports.size() == 0)
                note_failure($sformatf("result with none expected, phase %0d",
                                       result_ch.phase));
            else
            begin
                want = pending_reports.pop_front();
                check_field("running", 16'(want.running), 16'(result_ch.running));
                check_field("finished", 16'(want.finished), 16'(result_ch.finished));
                check_field("phase", 16'(want.phase), 16'(result_ch.phase));
                check_field("remaining_ticks", want.remaining, result_ch.remaining_ticks);
                check_field("inlet_open", 16'(want.inlet), 16'(result_ch.inlet_open));
                check_field("faucet_outlet_open", 16'(want.faucet),
                            16'(result_ch.faucet_outlet_open));
                check_field("drain_open", 16'(want.drain), 16'(result_ch.drain_open));
                check_field("vent_open", 16'(want.vent), 16'(result_ch.vent_open));
            end
        end
    end

    // Sink side: random stalls, or a long hold-off when one is requested
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                result_ch.ready <= 1'b0;
                sink_hold--;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog: too long without any transaction means the block has hung
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no transaction for %0d cycles", $realtime, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. All of them start and end on a falling edge.
    // ------------------------------------------------------------------

    // Offer one event, wait for acceptance, record the expected result.
    // Valid is left high on return; the caller either sends again or releases.
    task automatic send_event(input logic [1:0] act, input logic knd, input logic flt);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.action     <= act;
        item_ch.drain_kind <= knd;
        item_ch.fault      <= flt;
        do
            @(posedge clk);
        while (!item_ch.ready);
        pending_reports.push_back(advance_sequence(act, knd, flt));
        @(negedge clk);
    endtask

    // Mostly well-formed traffic: ticks with the odd fault, starts and stops,
    // a little of the unused code. Ignored fields carry random bits.
    task automatic send_random_event();
        int unsigned pick;
        logic [1:0]  act;
        logic        knd;
        logic        flt;
        pick = $urandom_range(0, 99);
        knd  = 1'($urandom_range(0, 1));
        flt  = 1'($urandom_range(0, 1));
        if (pick < 2)
            act = ACT_UNUSED;
        else if (pick < 8)
            act = ACT_START;
        else if (pick < 11)
            act = ACT_STOP;
        else
        begin
            act = ACT_TICK;
            flt = ($urandom_range(0, 39) == 0);
        end
        send_event(act, knd, flt);
    endtask

    // Sender pauses until every expected result is in and the block is quiet
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GUARD) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (idx)
            CFG_FAUCET_LIMIT: cfg_faucet_to = data;
            CFG_DRAIN_LIMIT:  cfg_drain_to  = data;
            CFG_SETTLE_TICKS: cfg_settle    = data[7:0];
            default:          ;
        endcase
    endtask

    // Only called with the block idle. Upper byte of the settle write is junk.
    task automatic apply_config(input logic [15:0] faucet_to, input logic [15:0] drain_to,
                                input logic [7:0] settle);
        write_reg(CFG_FAUCET_LIMIT, faucet_to);
        write_reg(CFG_DRAIN_LIMIT, drain_to);
        write_reg(CFG_SETTLE_TICKS, {8'($urandom_range(0, 255)), settle});
    endtask

    task automatic set_idle_mode(input int unsigned mode);
        case (mode)
            0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1:       begin src_idle_pct = 45; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 45; end
            default: begin src_idle_pct = 13; sink_stall_pct = 13; end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Events that must leave an idle block alone: faulted tick, unused code, stop
    task automatic test_idle_events();
        send_event(ACT_TICK, 1'b1, 1'b1);
        send_event(ACT_UNUSED, 1'b1, 1'b1);
        send_event(ACT_STOP, 1'b0, 1'b1);
    endtask

    // Reset timeouts are loaded on the first tick; a start mid-run restarts
    // with the new kind; stop sends the sequence to closing, fault then ignored.
    task automatic test_reset_timeouts();
        send_event(ACT_START, 1'b0, 1'b0);
        send_event(ACT_TICK, 1'b0, 1'b0);
        send_event(ACT_START, 1'b1, 1'b1);
        send_event(ACT_TICK, 1'b1, 1'b0);
        send_event(ACT_TICK, 1'b0, 1'b0);
        send_event(ACT_STOP, 1'b1, 1'b0);
        send_event(ACT_TICK, 1'b0, 1'b1);
        send_event(ACT_TICK, 1'b0, 1'b0);
    endtask

    // Full faucet run: ready, settle, draining down to zero, closing, done
    task automatic test_faucet_sequence();
        wait_idle();
        apply_config(16'd2, 16'd1, 8'd1);
        send_event(ACT_START, 1'b0, 1'b0);
        repeat (8) send_event(ACT_TICK, 1'b0, 1'b0);
    endtask

    // Drain-valve run cut short by a fault while draining; stop in done is a no-op
    task automatic test_fault_in_drain();
        send_event(ACT_START, 1'b1, 1'b0);
        send_event(ACT_TICK, 1'b0, 1'b0);
        send_event(ACT_TICK, 1'b0, 1'b0);
        send_event(ACT_TICK, 1'b0, 1'b0);
        send_event(ACT_TICK, 1'b1, 1'b1);
        send_event(ACT_STOP, 1'b0, 1'b0);
        send_event(ACT_TICK, 1'b0, 1'b0);
    endtask

    // Sink holds off for a long stretch while the sender keeps offering,
    // so the result register fills and the input stalls
    task automatic test_backpressure();
        wait_idle();
        set_idle_mode(0);
        sink_hold = SINK_HOLDOFF;
        repeat (40) send_random_event();
        wait_idle();
    endtask

    // Random traffic under several settings, extremes first, idle modes rotating
    task automatic test_random_settings();
        for (int unsigned s = 0; s < SETTING_COUNT; s++)
        begin
            wait_idle();
            case (s)
                0:       apply_config(16'd0, 16'd0, 8'd0);
                1:       apply_config(16'hFFFF, 16'd0, 8'd0);
                2:       apply_config(16'd0, 16'hFFFF, 8'hFF);
                default: apply_config(16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                                      8'($urandom_range(0, 4)));
            endcase
            set_idle_mode(s % 4);
            repeat (ITEMS_PER_SETTING) send_random_event();
        end
    endtask

    initial
    begin
        item_ch.valid      = 1'b0;
        item_ch.action     = ACT_TICK;
        item_ch.drain_kind = 1'b0;
        item_ch.fault      = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_FAUCET_LIMIT;
        cfg_data           = 16'd0;
        rst_n              = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_events();
        test_reset_timeouts();
        test_faucet_sequence();
        test_fault_in_drain();
        test_backpressure();
        test_random_settings();

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: cold_tank_drain_sequencer.f
design/ctds_pkg.sv
design/ctds_if.sv
design/ctds_next.sv
design/cold_tank_drain_sequencer.sv
test/cold_tank_drain_sequencer_test.sv
